[design/lphdp_pkg.sv]
// Shared types, constants and helper function of the land purchase hull block.
`default_nettype none

package lphdp_pkg;

	// Fixed widths of the stream fields.
	localparam int FIELD_W = 20;
	localparam int OUT_W   = 57;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 64;

	// Internal cost arithmetic wraps at 64 bits.
	localparam int CST_W = 64;
	// Width of one operand half fed to the shared multiplier.
	localparam int HALF_W = 32;

	typedef enum logic [4:0] {
		S_IDLE,
		S_UP,
		S_UP1,
		S_SOLVE,
		S_POP,
		S_POP1,
		S_POP2,
		S_DN,
		S_DN1,
		S_DN2,
		S_HT,
		S_HT1,
		S_ADD,
		S_ADD1,
		S_ADD2,
		S_MUL,
		S_CMP,
		S_PUSH,
		S_Q,
		S_Q1,
		S_Q2,
		S_Q3,
		S_Q4,
		S_F1,
		S_F2,
		S_DONE
	} state_t;

	// Saturating difference a - b, zero when b exceeds a.
	function automatic logic [CST_W-1:0] diff0(input logic [CST_W-1:0] a,
			input logic [CST_W-1:0] b);
		diff0 = (a > b) ? (a - b) : '0;
	endfunction

endpackage

`default_nettype wire

[design/lphdp_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module lphdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/land_purchase_hull_dp_top.sv]
// Top level of the land purchase hull block: heap sort, dominance filter and hull DP.
`default_nettype none

// Usage: rectangles arrive on the slave stream, one per transaction, with the
// width in s_tdata[19:0], the height in s_tdata[39:20] and tlast on the final
// rectangle of a set. Each rectangle is pushed into a max-heap in RAM as it
// arrives, with s_tready low meanwhile. Rectangles beyond MAX_ITEMS are
// dropped. After the tlast transaction the block pops the heap rectangle by
// rectangle, keeps only rectangles wider than every taller one, and runs the
// partition DP over a lower hull of lines held in a second RAM. Each hull
// insert checks lines from the top of the hull and each query searches it,
// all driven through one shared 32 by VALUE_BITS multiplier. One result
// transaction then carries the minimum cost in m_tdata[56:0].
// The result sits in an output register; the next set loads while it waits,
// and a finished set only stalls if the previous result is still not taken.
// Reset clears the count, the hull and the output valid; RAM contents are
// left undefined and are only read after being written.
module land_purchase_hull_dp_top #(
	parameter int MAX_ITEMS  = 65536,
	parameter int VALUE_BITS = 20
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// Fields from bit 0: rect_width[19:0], rect_height[39:20].
	input  wire logic [lphdp_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// Fields from bit 0: min_cost[56:0], zero padding above.
	output logic      [lphdp_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int VB   = VALUE_BITS;
	localparam int KW   = 2 * VB;
	localparam int AW   = $clog2(MAX_ITEMS);
	localparam int CNTW = $clog2(MAX_ITEMS + 1);
	localparam int CW   = lphdp_pkg::CST_W;
	localparam int HW   = CW + VB;
	localparam int HLF  = lphdp_pkg::HALF_W;
	localparam int PW   = HLF + VB;
	localparam int ACW  = CW + VB;

	lphdp_pkg::state_t state_q, state_d;

	// Control registers.
	logic [CNTW-1:0] cnt_q, hs_q, wp_q, top_q, t_q, lo_q, hi_q, bst_q, mid_q;
	logic [VB-1:0]   best_q;
	logic            m_tvalid_q;
	logic [2:0]      mstep_q;

	// Payload registers.
	logic [AW-1:0]   upi_q, di_q;
	logic [KW-1:0]   uk_q, root_q, dk_q, ca_q;
	logic            last_q;
	logic [VB-1:0]   m3_q, x_q, dm_q, opb1_q, opb2_q;
	logic [CW-1:0]   cost_q, db_q, fb_q, opa1_q, opa2_q;
	logic [HW-1:0]   e1_q, qm_q;
	logic [PW-1:0]   prod_q;
	logic [ACW-1:0]  acc1_q, acc2_q;
	logic [lphdp_pkg::OUT_W-1:0] cost_out_q;

	// RAM ports.
	logic            h_we, u_we;
	logic [AW-1:0]   h_waddr, h_raddr, u_waddr, u_raddr;
	logic [KW-1:0]   h_wdata, h_rdata;
	logic [HW-1:0]   u_wdata, u_rdata;

	// Shared multiplier operands.
	logic [HLF-1:0]  mul_a;
	logic [VB-1:0]   mul_b;

	// Helpers.
	logic [KW-1:0]   key_in;
	logic [AW-1:0]   par;
	logic [AW:0]     dn_c, dn_c1, hs_x;
	logic            cb_ok;
	logic [KW-1:0]   dn_sel;
	logic [AW-1:0]   dn_selidx;
	logic [CNTW-1:0] mid_c;
	logic            s_acc, keep_root, done_go;

	assign key_in    = {VB'(s_tdata[39:20]), VB'(s_tdata[19:0])};
	assign par       = (upi_q - AW'(1)) >> 1;
	assign dn_c      = {di_q, 1'b1};
	assign dn_c1     = dn_c + (AW + 1)'(1);
	assign hs_x      = (AW + 1)'(hs_q);
	assign cb_ok     = (dn_c1 < hs_x) && (h_rdata > ca_q);
	assign dn_sel    = cb_ok ? h_rdata : ca_q;
	assign dn_selidx = cb_ok ? dn_c1[AW-1:0] : dn_c[AW-1:0];
	assign mid_c     = lo_q + ((hi_q - lo_q) >> 1);
	assign s_acc     = s_tvalid && s_tready;
	assign keep_root = root_q[VB-1:0] > best_q;
	assign done_go   = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(lphdp_pkg::M_TDATA_W - lphdp_pkg::OUT_W){1'b0}}, cost_out_q};

	lphdp_ram #(.WIDTH(KW), .DEPTH(MAX_ITEMS)) u_heap (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	lphdp_ram #(.WIDTH(HW), .DEPTH(MAX_ITEMS)) u_hull (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (u_wdata),
		.raddr (u_raddr),
		.rdata (u_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lphdp_pkg::S_IDLE: begin
				if (s_acc) begin
					if (cnt_q < CNTW'(MAX_ITEMS)) begin
						state_d = lphdp_pkg::S_UP;
					end else if (s_tlast) begin
						state_d = lphdp_pkg::S_SOLVE;
					end
				end
			end
			lphdp_pkg::S_UP: begin
				if (upi_q == '0) begin
					state_d = last_q ? lphdp_pkg::S_SOLVE : lphdp_pkg::S_IDLE;
				end else begin
					state_d = lphdp_pkg::S_UP1;
				end
			end
			lphdp_pkg::S_UP1: begin
				if (h_rdata < uk_q) begin
					state_d = lphdp_pkg::S_UP;
				end else begin
					state_d = last_q ? lphdp_pkg::S_SOLVE : lphdp_pkg::S_IDLE;
				end
			end
			lphdp_pkg::S_SOLVE: state_d = lphdp_pkg::S_POP;
			lphdp_pkg::S_POP:   state_d = (hs_q == '0) ? lphdp_pkg::S_HT : lphdp_pkg::S_POP1;
			lphdp_pkg::S_POP1:  state_d = lphdp_pkg::S_POP2;
			lphdp_pkg::S_POP2: begin
				state_d = (hs_q == CNTW'(1)) ? lphdp_pkg::S_POP : lphdp_pkg::S_DN;
			end
			lphdp_pkg::S_DN: begin
				state_d = (dn_c >= hs_x) ? lphdp_pkg::S_POP : lphdp_pkg::S_DN1;
			end
			lphdp_pkg::S_DN1: state_d = lphdp_pkg::S_DN2;
			lphdp_pkg::S_DN2: begin
				state_d = (dk_q >= dn_sel) ? lphdp_pkg::S_POP : lphdp_pkg::S_DN;
			end
			lphdp_pkg::S_HT: begin
				state_d = (t_q == cnt_q) ? lphdp_pkg::S_DONE : lphdp_pkg::S_HT1;
			end
			lphdp_pkg::S_HT1: state_d = lphdp_pkg::S_ADD;
			lphdp_pkg::S_ADD: begin
				state_d = (top_q < CNTW'(2)) ? lphdp_pkg::S_PUSH : lphdp_pkg::S_ADD1;
			end
			lphdp_pkg::S_ADD1: state_d = lphdp_pkg::S_ADD2;
			lphdp_pkg::S_ADD2: state_d = lphdp_pkg::S_MUL;
			lphdp_pkg::S_MUL: begin
				if (mstep_q == 3'd4) begin
					state_d = lphdp_pkg::S_CMP;
				end
			end
			lphdp_pkg::S_CMP: begin
				state_d = (acc1_q <= acc2_q) ? lphdp_pkg::S_ADD : lphdp_pkg::S_PUSH;
			end
			lphdp_pkg::S_PUSH: state_d = lphdp_pkg::S_Q;
			lphdp_pkg::S_Q:    state_d = (lo_q < hi_q) ? lphdp_pkg::S_Q1 : lphdp_pkg::S_F1;
			lphdp_pkg::S_Q1:   state_d = lphdp_pkg::S_Q2;
			lphdp_pkg::S_Q2:   state_d = lphdp_pkg::S_Q3;
			lphdp_pkg::S_Q3:   state_d = lphdp_pkg::S_Q4;
			lphdp_pkg::S_Q4:   state_d = lphdp_pkg::S_Q;
			lphdp_pkg::S_F1:   state_d = lphdp_pkg::S_F2;
			lphdp_pkg::S_F2:   state_d = lphdp_pkg::S_HT;
			lphdp_pkg::S_DONE: begin
				if (done_go) begin
					state_d = lphdp_pkg::S_IDLE;
				end
			end
			default: state_d = lphdp_pkg::S_IDLE;
		endcase
	end

	// Outputs: RAM ports, multiplier operands and ready.
	always_comb begin
		s_tready = 1'b0;
		h_we     = 1'b0;
		h_waddr  = '0;
		h_wdata  = uk_q;
		h_raddr  = '0;
		u_we     = 1'b0;
		u_waddr  = top_q[AW-1:0];
		u_wdata  = {cost_q, m3_q};
		u_raddr  = '0;
		mul_a    = '0;
		mul_b    = x_q;
		unique case (state_q)
			lphdp_pkg::S_IDLE: s_tready = 1'b1;
			lphdp_pkg::S_UP: begin
				if (upi_q == '0) begin
					h_we    = 1'b1;
					h_waddr = '0;
				end
				h_raddr = par;
			end
			lphdp_pkg::S_UP1: begin
				h_we    = 1'b1;
				h_waddr = upi_q;
				h_wdata = (h_rdata < uk_q) ? h_rdata : uk_q;
			end
			lphdp_pkg::S_POP1: h_raddr = AW'(hs_q - CNTW'(1));
			lphdp_pkg::S_POP2: begin
				h_we    = keep_root;
				h_waddr = AW'(wp_q - CNTW'(1));
				h_wdata = root_q;
			end
			lphdp_pkg::S_DN: begin
				if (dn_c >= hs_x) begin
					h_we    = 1'b1;
					h_waddr = di_q;
					h_wdata = dk_q;
				end
				h_raddr = dn_c[AW-1:0];
			end
			lphdp_pkg::S_DN1: h_raddr = dn_c1[AW-1:0];
			lphdp_pkg::S_DN2: begin
				h_we    = 1'b1;
				h_waddr = di_q;
				h_wdata = (dk_q >= dn_sel) ? dk_q : dn_sel;
			end
			lphdp_pkg::S_HT:   h_raddr = AW'(t_q);
			lphdp_pkg::S_ADD:  u_raddr = AW'(top_q - CNTW'(2));
			lphdp_pkg::S_ADD1: u_raddr = AW'(top_q - CNTW'(1));
			lphdp_pkg::S_MUL: begin
				case (mstep_q)
					3'd0: begin
						mul_a = opa1_q[HLF-1:0];
						mul_b = opb1_q;
					end
					3'd1: begin
						mul_a = opa1_q[CW-1:HLF];
						mul_b = opb1_q;
					end
					3'd2: begin
						mul_a = opa2_q[HLF-1:0];
						mul_b = opb2_q;
					end
					3'd3: begin
						mul_a = opa2_q[CW-1:HLF];
						mul_b = opb2_q;
					end
					default: mul_a = '0;
				endcase
			end
			lphdp_pkg::S_PUSH: u_we    = (top_q < CNTW'(MAX_ITEMS));
			lphdp_pkg::S_Q:    u_raddr = (lo_q < hi_q) ? AW'(mid_c) : AW'(bst_q);
			lphdp_pkg::S_Q1:   u_raddr = AW'(mid_q - CNTW'(1));
			lphdp_pkg::S_Q3:   mul_a   = HLF'(dm_q);
			lphdp_pkg::S_F1:   mul_a   = HLF'(u_rdata[VB-1:0]);
			default: s_tready = 1'b0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lphdp_pkg::S_IDLE;
			cnt_q      <= '0;
			hs_q       <= '0;
			wp_q       <= '0;
			top_q      <= '0;
			best_q     <= '0;
			m_tvalid_q <= 1'b0;
			mstep_q    <= '0;
		end else begin
			state_q <= state_d;
			// A finished set raises valid; otherwise a taken result drops it.
			if (state_q == lphdp_pkg::S_DONE && done_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				lphdp_pkg::S_IDLE: begin
					if (s_acc && cnt_q < CNTW'(MAX_ITEMS)) begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				lphdp_pkg::S_SOLVE: begin
					hs_q   <= cnt_q;
					wp_q   <= cnt_q;
					best_q <= '0;
				end
				lphdp_pkg::S_POP: begin
					if (hs_q == '0) begin
						top_q <= '0;
					end
				end
				lphdp_pkg::S_POP2: begin
					hs_q <= hs_q - CNTW'(1);
					if (keep_root) begin
						best_q <= root_q[VB-1:0];
						wp_q   <= wp_q - CNTW'(1);
					end
				end
				lphdp_pkg::S_ADD2: mstep_q <= '0;
				lphdp_pkg::S_MUL:  mstep_q <= mstep_q + 3'd1;
				lphdp_pkg::S_CMP: begin
					if (acc1_q <= acc2_q) begin
						top_q <= top_q - CNTW'(1);
					end
				end
				lphdp_pkg::S_PUSH: begin
					if (top_q < CNTW'(MAX_ITEMS)) begin
						top_q <= top_q + CNTW'(1);
					end
				end
				lphdp_pkg::S_DONE: begin
					if (done_go) begin
						cnt_q  <= '0;
						top_q  <= '0;
						best_q <= '0;
					end
				end
				default: mstep_q <= mstep_q;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
		unique case (state_q)
			lphdp_pkg::S_IDLE: begin
				if (s_acc) begin
					upi_q  <= cnt_q[AW-1:0];
					uk_q   <= key_in;
					last_q <= s_tlast;
				end
			end
			lphdp_pkg::S_UP1: begin
				if (h_rdata < uk_q) begin
					upi_q <= par;
				end
			end
			lphdp_pkg::S_POP: begin
				t_q    <= wp_q;
				cost_q <= '0;
			end
			lphdp_pkg::S_POP1: root_q <= h_rdata;
			lphdp_pkg::S_POP2: begin
				dk_q <= h_rdata;
				di_q <= '0;
			end
			lphdp_pkg::S_DN1: ca_q <= h_rdata;
			lphdp_pkg::S_DN2: di_q <= dn_selidx;
			lphdp_pkg::S_HT1: begin
				m3_q <= h_rdata[VB-1:0];
				x_q  <= h_rdata[KW-1:VB];
			end
			lphdp_pkg::S_ADD1: e1_q <= u_rdata;
			lphdp_pkg::S_ADD2: begin
				opa1_q <= lphdp_pkg::diff0(cost_q, u_rdata[HW-1:VB]);
				opb1_q <= e1_q[VB-1:0] - u_rdata[VB-1:0];
				opa2_q <= lphdp_pkg::diff0(u_rdata[HW-1:VB], e1_q[HW-1:VB]);
				opb2_q <= u_rdata[VB-1:0] - m3_q;
			end
			lphdp_pkg::S_MUL: begin
				case (mstep_q)
					3'd1: acc1_q <= ACW'(prod_q);
					3'd2: acc1_q <= acc1_q + (ACW'(prod_q) << HLF);
					3'd3: acc2_q <= ACW'(prod_q);
					3'd4: acc2_q <= acc2_q + (ACW'(prod_q) << HLF);
					default: acc1_q <= acc1_q;
				endcase
			end
			lphdp_pkg::S_PUSH: begin
				lo_q  <= CNTW'(1);
				bst_q <= '0;
				hi_q  <= (top_q < CNTW'(MAX_ITEMS)) ? top_q + CNTW'(1) : top_q;
			end
			lphdp_pkg::S_Q:  mid_q <= mid_c;
			lphdp_pkg::S_Q1: qm_q  <= u_rdata;
			lphdp_pkg::S_Q2: begin
				dm_q <= u_rdata[VB-1:0] - qm_q[VB-1:0];
				db_q <= lphdp_pkg::diff0(qm_q[HW-1:VB], u_rdata[HW-1:VB]);
			end
			lphdp_pkg::S_Q4: begin
				if (db_q <= CW'(prod_q)) begin
					bst_q <= mid_q;
					lo_q  <= mid_q + CNTW'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			lphdp_pkg::S_F1: fb_q <= u_rdata[HW-1:VB];
			lphdp_pkg::S_F2: begin
				cost_q <= fb_q + CW'(prod_q);
				t_q    <= t_q + CNTW'(1);
			end
			lphdp_pkg::S_DONE: begin
				if (done_go) begin
					cost_out_q <= cost_q[lphdp_pkg::OUT_W-1:0];
				end
			end
			default: last_q <= last_q;
		endcase
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(MAX_ITEMS))
		else $error("rectangle count exceeds store depth");

	a_wp_hs: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q >= hs_q)
		else $error("kept list overlaps live heap");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lphdp_pkg::S_IDLE) |-> (top_q == '0 && best_q == '0))
		else $error("hull or scan state not cleared while idle");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> (state_q != lphdp_pkg::S_IDLE))
		else $error("final transaction did not start a solve");
`endif

endmodule

`default_nettype wire
